/* hw/rtl/nfcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NAND flash command sequencer package
// Shared types, command codes and sizes for the sequencer front, queue and
// back end.
// ----------------------------------------------------------------------------
package nfcs_pkg;

  // Pages in one erase block; the erase row is block index times this.
  localparam int BLOCK_PAGES = 64;

  // Depth of the operation queue between front and back end.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // NAND command bytes.
  localparam logic [7:0] CMD_READ_ID    = 8'h90;
  localparam logic [7:0] CMD_READ_SETUP = 8'h00;
  localparam logic [7:0] CMD_READ_CONF  = 8'h30;
  localparam logic [7:0] CMD_PROG_SETUP = 8'h80;
  localparam logic [7:0] CMD_PROG_CONF  = 8'h10;
  localparam logic [7:0] CMD_ERASE_SETUP = 8'h60;
  localparam logic [7:0] CMD_ERASE_CONF = 8'hD0;
  localparam logic [7:0] CMD_STATUS     = 8'h70;
  localparam logic [7:0] ADDR_ZERO      = 8'h00;

  typedef enum logic [2:0] {
    OP_READ_ID     = 3'd0,
    OP_PAGE_READ   = 3'd1,
    OP_PROG_START  = 3'd2,
    OP_DATA_WRITE  = 3'd3,
    OP_DATA_READ   = 3'd4,
    OP_PROG_FINISH = 3'd5,
    OP_ERASE       = 3'd6,
    OP_STATUS      = 3'd7
  } op_kind_t;

  typedef enum logic [2:0] {
    CY_CMD  = 3'd0,
    CY_ADDR = 3'd1,
    CY_WR   = 3'd2,
    CY_RD   = 3'd3,
    CY_WAIT = 3'd4
  } cyc_type_t;

  typedef enum logic [2:0] {
    WS_NONE  = 3'd0,
    WS_A2D   = 3'd1,
    WS_W2R   = 3'd2,
    WS_PROG  = 3'd3,
    WS_ERASE = 3'd4
  } wait_sel_t;

  typedef enum logic [1:0] {
    CFG_ADDR_TO_DATA  = 2'd0,
    CFG_WRITE_TO_READ = 2'd1,
    CFG_PROGRAM_WAIT  = 2'd2,
    CFG_ERASE_WAIT    = 2'd3
  } cfg_idx_t;

  // Classified operation: kind, write-protect level and the four operand
  // bytes the back end may place on the bus.
  typedef struct packed {
    op_kind_t   kind;
    logic       wp;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } desc_t;

  typedef struct packed {
    logic [15:0] addr_to_data;
    logic [15:0] write_to_read;
    logic [23:0] program_wait;
    logic [23:0] erase_wait;
  } cfg_t;

endpackage : nfcs_pkg
`default_nettype wire

/* hw/rtl/nand_flash_command_sequencer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// With the back end idle, a request's beat is first written into the operation queue, and its
// first bus cycle is then registered into the output stage before it appears on out_.
// Throughput: one bus-cycle beat per clock while an operation is queued and out_tready is high;
// a request holds the back end until its last bus cycle is produced, then the next queued one starts.
// The input side takes a beat whenever the two-entry operation queue has room.
// Reset (rst_n low, synchronous) empties the queue and output stage and loads the
// wait registers with their defaults: 100, 60, 700000 and 10000000 ticks.
// ----------------------------------------------------------------------------
// NAND flash command sequencer
// Turns NAND operation requests into runs of command, address, data and wait
// bus cycles. A combinational front end classifies each request into a
// descriptor holding its operand bytes and write-protect level; the
// descriptor waits in a short queue; the back end walks the operation's cycle table
// one step per clock, when the output stage is empty or drains, into a registered
// output stage, so the input side keeps accepting while results are still being taken.
// ----------------------------------------------------------------------------
module nand_flash_command_sequencer_top
  import nfcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,   // [2:0] kind
  input  wire logic [47:0] in_tdata,   // [15:0] row_page, [26:16] column,
                                       // [36:27] erase_index, [44:37] write_byte
  // Bus-cycle channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [2:0]       out_tuser,  // [2:0] cycle_type
  output logic [39:0]      out_tdata,  // [7:0] bus_byte, [31:8] wait_ticks,
                                       // [32] write_protect_high
  output logic             out_tlast,  // last_cycle
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  desc_t push_desc;
  desc_t head_desc;

  // Wait-length registers. Each write is masked to the register's width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_ADDR_TO_DATA:  cfg_nxt.addr_to_data  = cfg_wdata[15:0];
        CFG_WRITE_TO_READ: cfg_nxt.write_to_read = cfg_wdata[15:0];
        CFG_PROGRAM_WAIT:  cfg_nxt.program_wait  = cfg_wdata;
        CFG_ERASE_WAIT:    cfg_nxt.erase_wait    = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.addr_to_data  <= 16'd100;
      cfg_r.write_to_read <= 16'd60;
      cfg_r.program_wait  <= 24'd700000;
      cfg_r.erase_wait    <= 24'd10000000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: classification of each request beat.
  nfcs_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  // Decoupling queue so that either side can stall on its own.
  nfcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  // Back end: cycle sequencing and the registered output stage.
  nfcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_desc     (head_desc),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule : nand_flash_command_sequencer_top
`default_nettype wire

/* hw/rtl/nfcs_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NAND sequencer front end
// Accepts request beats and classifies them into operation descriptors.
// ----------------------------------------------------------------------------
module nfcs_front
  import nfcs_pkg::*;
(
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,   // kind
  input  wire logic [47:0] in_tdata,   // row_page, column, erase_index, write_byte
  input  wire logic        q_full,
  output logic             q_push,
  output desc_t            q_desc
);

  logic [15:0] row;
  logic [10:0] col;
  logic [9:0]  blk;
  logic [7:0]  wbyte;
  logic [15:0] erow;
  op_kind_t    kind;

  assign kind  = op_kind_t'(in_tuser);
  assign row   = in_tdata[15:0];
  assign col   = in_tdata[26:16];
  assign blk   = in_tdata[36:27];
  assign wbyte = in_tdata[44:37];
  // Block index times pages per block, wrapping at 16 bits.
  assign erow  = 16'({22'd0, blk} * 32'(BLOCK_PAGES));

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_desc      = '0;
    q_desc.kind = kind;
    q_desc.wp   = (kind inside {OP_PROG_START, OP_DATA_WRITE, OP_PROG_FINISH, OP_ERASE});
    case (kind)
      OP_PAGE_READ: begin
        q_desc.b0 = col[7:0];
        q_desc.b1 = {5'd0, col[10:8]};
        q_desc.b2 = row[7:0];
        q_desc.b3 = row[15:8];
      end
      OP_PROG_START: begin
        q_desc.b2 = row[7:0];
        q_desc.b3 = row[15:8];
      end
      OP_DATA_WRITE: begin
        q_desc.b0 = wbyte;
      end
      OP_ERASE: begin
        q_desc.b0 = erow[7:0];
        q_desc.b1 = erow[15:8];
      end
      default: begin
      end
    endcase
  end

endmodule : nfcs_front
`default_nettype wire

/* hw/rtl/nfcs_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NAND sequencer operation queue
// Small register FIFO of descriptors between front and back end.
// ----------------------------------------------------------------------------
module nfcs_queue
  import nfcs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  desc_t      push_desc,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output desc_t      head_desc
);

  desc_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule : nfcs_queue
`default_nettype wire

/* hw/rtl/nfcs_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NAND sequencer back end
// Steps through the bus cycles of the operation at the queue head and
// presents them through a registered output stage.
// ----------------------------------------------------------------------------
module nfcs_back
  import nfcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cfg_t             cfg,
  input  wire logic        q_valid,
  input  desc_t            q_desc,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [2:0]       out_tuser,  // cycle_type
  output logic [39:0]      out_tdata,  // bus_byte, wait_ticks, write_protect_high
  output logic             out_tlast   // last_cycle
);

  typedef struct packed {
    cyc_type_t  ctype;
    logic [7:0] bus_byte;
    wait_sel_t  wsel;
    logic       last;
  } cyc_t;

  logic [2:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  cyc_type_t   out_type_r;
  logic [7:0]  out_byte_r;
  logic [23:0] out_ticks_r;
  logic        out_wp_r;
  logic        out_last_r;
  logic        advance;
  cyc_t        cyc;
  logic [23:0] ticks;

  function automatic cyc_t mk(input cyc_type_t t, input logic [7:0] b, input wait_sel_t w,
                              input logic l);
    cyc_t c;
    c.ctype    = t;
    c.bus_byte = b;
    c.wsel     = w;
    c.last     = l;
    return c;
  endfunction

  // Cycle table: what step_r of each operation puts on the bus.
  always_comb begin
    cyc = mk(CY_RD, ADDR_ZERO, WS_NONE, 1'b1);
    case (q_desc.kind)
      OP_READ_ID: begin
        case (step_r)
          3'd0:    cyc = mk(CY_CMD, CMD_READ_ID, WS_NONE, 1'b0);
          3'd1:    cyc = mk(CY_ADDR, ADDR_ZERO, WS_NONE, 1'b0);
          default: cyc = mk(CY_WAIT, ADDR_ZERO, WS_W2R, 1'b1);
        endcase
      end
      OP_PAGE_READ: begin
        case (step_r)
          3'd0:    cyc = mk(CY_CMD, CMD_READ_SETUP, WS_NONE, 1'b0);
          3'd1:    cyc = mk(CY_ADDR, q_desc.b0, WS_NONE, 1'b0);
          3'd2:    cyc = mk(CY_ADDR, q_desc.b1, WS_NONE, 1'b0);
          3'd3:    cyc = mk(CY_ADDR, q_desc.b2, WS_NONE, 1'b0);
          3'd4:    cyc = mk(CY_ADDR, q_desc.b3, WS_NONE, 1'b0);
          3'd5:    cyc = mk(CY_CMD, CMD_READ_CONF, WS_NONE, 1'b0);
          default: cyc = mk(CY_WAIT, ADDR_ZERO, WS_W2R, 1'b1);
        endcase
      end
      OP_PROG_START: begin
        case (step_r)
          3'd0:    cyc = mk(CY_CMD, CMD_PROG_SETUP, WS_NONE, 1'b0);
          3'd1:    cyc = mk(CY_ADDR, q_desc.b0, WS_NONE, 1'b0);
          3'd2:    cyc = mk(CY_ADDR, q_desc.b1, WS_NONE, 1'b0);
          3'd3:    cyc = mk(CY_ADDR, q_desc.b2, WS_NONE, 1'b0);
          3'd4:    cyc = mk(CY_ADDR, q_desc.b3, WS_NONE, 1'b0);
          default: cyc = mk(CY_WAIT, ADDR_ZERO, WS_A2D, 1'b1);
        endcase
      end
      OP_DATA_WRITE: cyc = mk(CY_WR, q_desc.b0, WS_NONE, 1'b1);
      OP_DATA_READ:  cyc = mk(CY_RD, ADDR_ZERO, WS_NONE, 1'b1);
      OP_PROG_FINISH: begin
        case (step_r)
          3'd0:    cyc = mk(CY_CMD, CMD_PROG_CONF, WS_NONE, 1'b0);
          3'd1:    cyc = mk(CY_WAIT, ADDR_ZERO, WS_PROG, 1'b0);
          3'd2:    cyc = mk(CY_CMD, CMD_STATUS, WS_NONE, 1'b0);
          3'd3:    cyc = mk(CY_WAIT, ADDR_ZERO, WS_W2R, 1'b0);
          default: cyc = mk(CY_RD, ADDR_ZERO, WS_NONE, 1'b1);
        endcase
      end
      OP_ERASE: begin
        case (step_r)
          3'd0:    cyc = mk(CY_CMD, CMD_ERASE_SETUP, WS_NONE, 1'b0);
          3'd1:    cyc = mk(CY_ADDR, q_desc.b0, WS_NONE, 1'b0);
          3'd2:    cyc = mk(CY_ADDR, q_desc.b1, WS_NONE, 1'b0);
          3'd3:    cyc = mk(CY_CMD, CMD_ERASE_CONF, WS_NONE, 1'b0);
          3'd4:    cyc = mk(CY_WAIT, ADDR_ZERO, WS_ERASE, 1'b0);
          3'd5:    cyc = mk(CY_CMD, CMD_STATUS, WS_NONE, 1'b0);
          3'd6:    cyc = mk(CY_WAIT, ADDR_ZERO, WS_W2R, 1'b0);
          default: cyc = mk(CY_RD, ADDR_ZERO, WS_NONE, 1'b1);
        endcase
      end
      OP_STATUS: begin
        case (step_r)
          3'd0:    cyc = mk(CY_CMD, CMD_STATUS, WS_NONE, 1'b0);
          3'd1:    cyc = mk(CY_WAIT, ADDR_ZERO, WS_W2R, 1'b0);
          default: cyc = mk(CY_RD, ADDR_ZERO, WS_NONE, 1'b1);
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cyc.wsel)
      WS_A2D:   ticks = {8'd0, cfg.addr_to_data};
      WS_W2R:   ticks = {8'd0, cfg.write_to_read};
      WS_PROG:  ticks = cfg.program_wait;
      WS_ERASE: ticks = cfg.erase_wait;
      default:  ticks = '0;
    endcase
  end

  // A new cycle is produced whenever the queue holds an operation and the output stage is empty or drains.
  assign advance = q_valid && (!out_valid_r || out_tready);
  assign q_pop   = advance && cyc.last;

  always_comb begin
    step_nxt = step_r;
    if (advance) begin
      step_nxt = cyc.last ? 3'd0 : step_r + 3'd1;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_type_r  <= cyc.ctype;
      out_byte_r  <= cyc.bus_byte;
      out_ticks_r <= ticks;
      out_wp_r    <= q_desc.wp;
      out_last_r  <= cyc.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_type_r;
  assign out_tdata  = {7'd0, out_wp_r, out_ticks_r, out_byte_r};
  assign out_tlast  = out_last_r;

  // The final cycle of an operation is the one that retires it from the queue.
  a_pop_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && out_last_r))
    else $error("queue pop without a last cycle in the output stage");

  // A partly sequenced operation stays at the queue head.
  a_step_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != 3'd0) |-> q_valid)
    else $error("step counter running with an empty queue");

  // Steps move on by one until the last cycle of the run.
  a_step_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !cyc.last) |=> (step_r == $past(step_r) + 3'd1))
    else $error("step counter skipped a cycle");

endmodule : nfcs_back
`default_nettype wire
